// File: rtl/core/keyed_table_prng_stream_assert.svh
// ----------------------------------------------------------------------------
// keyed_table_prng_stream assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_TABLE_PRNG_STREAM_ASSERT_SVH
`define KEYED_TABLE_PRNG_STREAM_ASSERT_SVH

// same-cycle implication
`define KTPS_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("keyed_table_prng_stream: assertion failed");

// next-cycle implication
`define KTPS_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("keyed_table_prng_stream: assertion failed");

`endif

// File: rtl/core/ktps_pkg.sv
// ----------------------------------------------------------------------------
// ktps_pkg
// Shared constants, types and helpers of the keyed word generator.
// ----------------------------------------------------------------------------
package ktps_pkg;

    localparam logic [31:0] MIX_C1    = 32'h85ebca6b;
    localparam logic [31:0] MIX_C2    = 32'hc2b2ae35;
    localparam logic [31:0] TAB_GUARD = 32'h6c26fc92;
    localparam logic [31:0] TAB_MUL   = 32'h06a0dd9b;
    localparam logic [31:0] WEYL_STEP = 32'h9e3779b9;
    localparam int unsigned XS_MID    = 13;
    localparam int unsigned XS_HALF   = 16;

    localparam logic [7:0]  TAP_START   = 8'hff;
    localparam logic [2:0]  TAP_FIRST_N = 3'd6;
    localparam logic [2:0]  TAP_FIRST_W = 3'd0;
    localparam logic [2:0]  TAP_LAST    = 3'd7;

    localparam logic [31:0] SEED_KEY_RST  = 32'h0;
    localparam logic [7:0]  RUN_LEN_RST   = 8'hff;
    localparam logic        WIDE_TAPS_RST = 1'b0;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_KEY  = 2'd0,
        CFG_RUN_LEN   = 2'd1,
        CFG_WIDE_TAPS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] seed_key;
        logic [7:0]  run_len;
        logic        wide_taps;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic restart;
    } t_q_head;

    typedef struct packed {
        logic pop;
        logic done;
    } t_eng_stat;

    typedef enum logic [3:0] {
        S_KEY_MUL,
        S_MIX1,
        S_MIX2,
        S_MIX_END,
        S_IDLE,
        S_TAP_J,
        S_TAP_K,
        S_TAP_R,
        S_WORD_A,
        S_WORD_B
    } t_state;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
        logic [5:0] rc;
        rc = 6'd32 - {1'b0, r};
        return (v << r) | (v >> rc);
    endfunction

    function automatic logic [7:0] norm_len(input logic [7:0] bl);
        return (bl == 8'd0) ? 8'd1 : bl;
    endfunction

endpackage

// File: rtl/core/keyed_table_prng_stream.sv
// ----------------------------------------------------------------------------
// keyed_table_prng_stream
// Keyed 32-bit word generator, one word per request, rekeyed per block.
// ----------------------------------------------------------------------------
// Each request yields one word; restart reloads the key from seed_key first.
// A word steps through three tap states per tap (two taps in two-tap mode,
// eight in eight-tap mode) plus fetch and update states, all on one shared
// 32x32 multiplier that forms each table word. A block start (after reset,
// on restart and after the last word of a block) adds the key term hash
// on the same multiplier. Requests queue in front of the engine,
// and a finished word waits in the output register while the next runs.
// Configuration writes are always ready.
`include "keyed_table_prng_stream_assert.svh"

module keyed_table_prng_stream
    import ktps_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_word,
    output logic                 o_block_end,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg      r_cfg;
    t_q_head   w_head;
    t_eng_stat w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed_key  <= SEED_KEY_RST;
            r_cfg.run_len   <= RUN_LEN_RST;
            r_cfg.wide_taps <= WIDE_TAPS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SEED_KEY:  r_cfg.seed_key  <= i_cfg_data;
                CFG_RUN_LEN:   r_cfg.run_len   <= i_cfg_data[7:0];
                CFG_WIDE_TAPS: r_cfg.wide_taps <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ktps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_restart  (i_restart),
        .i_pop      (w_stat.pop),
        .o_head     (w_head)
    );

    ktps_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (w_head),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_word      (o_word),
        .o_block_end (o_block_end)
    );

    `KTPS_ASSERT_IMP(a_pop_has_request, w_stat.pop, w_head.valid)
    `KTPS_ASSERT_NXT(a_accept_fills_queue, i_in_valid && !o_in_stall, w_head.valid)
    `KTPS_ASSERT_NXT(a_done_shows_word, w_stat.done, o_out_valid)
    `KTPS_ASSERT_IMP(a_word_from_engine, $rose(o_out_valid), $past(w_stat.done))

endmodule

// File: rtl/core/ktps_queue.sv
// ----------------------------------------------------------------------------
// ktps_queue
// Front end: takes requests, tags restart, holds them for the engine.
// ----------------------------------------------------------------------------
module ktps_queue
    import ktps_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_restart,
    input  logic    i_pop,
    output t_q_head o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_in_stall     = (r_cnt == CNT_FULL);
    assign push           = i_in_valid && !o_in_stall;
    assign pop            = i_pop && (r_cnt != '0);
    assign o_head.valid   = (r_cnt != '0);
    assign o_head.restart = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/ktps_engine.sv
// ----------------------------------------------------------------------------
// ktps_engine
// Back end: block rekeying, tap mix over a shared multiplier, word update
// and output register.
// ----------------------------------------------------------------------------
module ktps_engine
    import ktps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_q_head     i_head,
    output t_eng_stat   o_stat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_word,
    output logic        o_block_end
);

    t_state      r_state, n_state;
    logic [31:0] r_key, r_kt, r_acc, r_o, r_p, r_word;
    logic [7:0]  r_d, r_tap, r_left;
    logic [2:0]  r_k;
    logic        r_pend, r_ov, r_bend;

    logic [31:0] mul_a, mul_b, prod;
    logic        p_load, kt_load, tap_init, tap_acc, a_load, pop, done;
    logic        out_free, last;
    logic [7:0]  tap_j;
    logic [31:0] h0, h1, h2, mix_end, sum_ka, a_val, b_val, c_val;

    assign out_free = !r_ov || !i_out_stall;
    assign last     = (r_left <= 8'd1);
    assign tap_j    = r_tap + {5'd0, r_k};
    assign prod     = mul_a * mul_b;

    assign h0      = TAB_GUARD ^ r_p;
    assign h1      = h0 ^ (h0 >> XS_HALF);
    assign h2      = r_p ^ (r_p >> XS_MID);
    assign mix_end = r_p ^ (r_p >> XS_HALF);

    assign sum_ka = r_key + r_acc;
    assign a_val  = ({24'd0, r_d} ^ r_o) ^ sum_ka;
    assign b_val  = sum_ka ^ (r_o + {24'd0, r_d});
    assign c_val  = rotl32((r_acc >> XS_MID) ^ r_acc, b_val[4:0]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_KEY_MUL: n_state = S_MIX1;
            S_MIX1:    n_state = S_MIX2;
            S_MIX2:    n_state = S_MIX_END;
            S_MIX_END: n_state = r_pend ? S_TAP_J : S_IDLE;
            S_IDLE: begin
                if (i_head.valid) begin
                    n_state = i_head.restart ? S_KEY_MUL : S_TAP_J;
                end
            end
            S_TAP_J:   n_state = S_TAP_K;
            S_TAP_K:   n_state = S_TAP_R;
            S_TAP_R:   n_state = (r_k == TAP_LAST) ? S_WORD_A : S_TAP_J;
            S_WORD_A:  n_state = S_WORD_B;
            S_WORD_B: begin
                if (out_free) begin
                    n_state = last ? S_KEY_MUL : S_IDLE;
                end
            end
            default:   n_state = S_KEY_MUL;
        endcase
    end

    always_comb begin
        mul_a    = r_key;
        mul_b    = TAB_MUL;
        p_load   = 1'b0;
        kt_load  = 1'b0;
        tap_init = 1'b0;
        tap_acc  = 1'b0;
        a_load   = 1'b0;
        pop      = 1'b0;
        done     = 1'b0;
        case (r_state)
            S_KEY_MUL: p_load = 1'b1;
            S_MIX1: begin
                mul_a  = h1;
                mul_b  = MIX_C1;
                p_load = 1'b1;
            end
            S_MIX2: begin
                mul_a  = h2;
                mul_b  = MIX_C2;
                p_load = 1'b1;
            end
            S_MIX_END: begin
                kt_load  = 1'b1;
                tap_init = r_pend;
            end
            S_IDLE: begin
                pop      = i_head.valid;
                tap_init = i_head.valid && !i_head.restart;
            end
            S_TAP_J: begin
                mul_a  = {24'd0, tap_j};
                mul_b  = TAB_MUL;
                p_load = 1'b1;
            end
            S_TAP_K: begin
                mul_a  = r_p;
                mul_b  = r_kt;
                p_load = 1'b1;
            end
            S_TAP_R:  tap_acc = 1'b1;
            S_WORD_A: a_load = 1'b1;
            S_WORD_B: done = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_KEY_MUL;
            r_key   <= SEED_KEY_RST;
            r_left  <= norm_len(RUN_LEN_RST);
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_pend <= 1'b1;
                if (i_head.restart) begin
                    r_key  <= i_cfg.seed_key;
                    r_left <= norm_len(i_cfg.run_len);
                end
            end
            if (done) begin
                r_pend <= 1'b0;
                if (last) begin
                    r_key  <= r_key + WEYL_STEP;
                    r_left <= norm_len(i_cfg.run_len);
                end else begin
                    r_left <= r_left - 8'd1;
                end
            end
            if (done) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_load) begin
            r_p <= prod;
        end
        if (kt_load) begin
            r_kt  <= mix_end;
            r_acc <= r_key;
            r_d   <= 8'd0;
            r_tap <= TAP_START;
        end
        if (tap_init) begin
            r_k <= i_cfg.wide_taps ? TAP_FIRST_W : TAP_FIRST_N;
            r_o <= 32'd0;
        end
        if (tap_acc) begin
            r_o <= r_o ^ (rotl32(r_p, r_key[4:0] ^ tap_j[4:0]) << r_k);
            if (r_k != TAP_LAST) begin
                r_k <= r_k + 3'd1;
            end
        end
        if (a_load) begin
            r_acc <= a_val;
        end
        if (done) begin
            r_d    <= c_val[7:0];
            r_word <= c_val;
            r_bend <= last;
            if (!last) begin
                r_tap <= r_tap - 8'd1;
            end
        end
    end

    assign o_stat.pop  = pop;
    assign o_stat.done = done;
    assign o_out_valid = r_ov;
    assign o_word      = r_word;
    assign o_block_end = r_bend;

endmodule

// File: dv/keyed_table_prng_stream_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_table_prng_stream_test
// Self-checking bench for the keyed word generator. A tracker follows the
// block key, key term and word recurrence for every accepted request and
// holds the expected words in order; a monitor compares each accepted word
// and block-end flag. Directed cases come first, then random phases with
// varied register settings, sender and receiver idling, and one long output
// hold-off that backs up the request side.
// ----------------------------------------------------------------------------
import ktps_pkg::*;

typedef struct packed {
    logic [31:0] word;
    logic        block_end;
} t_word_res;

class keyed_word_tracker;
    localparam int REPORT_LIMIT = 100;

    logic [31:0] seed_key;
    logic [7:0]  run_len;
    logic        wide_taps;
    logic [31:0] blk_key;
    logic [31:0] key_term;
    logic [31:0] acc_a;
    logic [7:0]  low_byte;
    logic [7:0]  tap_pos;
    logic [7:0]  words_left;
    t_word_res   pending_words[$];
    int          err_cnt;
    int          word_cnt;
    int          block_cnt;
    int          restart_cnt;
    int          wide_cnt;

    function new();
        seed_key    = SEED_KEY_RST;
        run_len     = RUN_LEN_RST;
        wide_taps   = WIDE_TAPS_RST;
        blk_key     = seed_key;
        err_cnt     = 0;
        word_cnt    = 0;
        block_cnt   = 0;
        restart_cnt = 0;
        wide_cnt    = 0;
        start_block();
    endfunction

    function logic [31:0] rot_left(logic [31:0] v, logic [31:0] r);
        logic [4:0] s;
        s = r[4:0];
        if (s == 5'd0) begin
            return v;
        end
        return (v << s) | (v >> (6'd32 - s));
    endfunction

    function logic [31:0] fmix(logic [31:0] h);
        logic [31:0] v;
        v = h ^ (h >> XS_HALF);
        v = v * MIX_C1;
        v = v ^ (v >> XS_MID);
        v = v * MIX_C2;
        return v ^ (v >> XS_HALF);
    endfunction

    function logic [31:0] table_word(logic [7:0] j);
        return rot_left((32'(j) * TAB_MUL) * key_term, blk_key ^ 32'(j));
    endfunction

    function void start_block();
        key_term   = fmix(TAB_GUARD ^ (TAB_MUL * blk_key));
        acc_a      = blk_key;
        low_byte   = 8'd0;
        tap_pos    = TAP_START;
        words_left = (run_len == 8'd0) ? 8'd1 : run_len;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            CFG_SEED_KEY:  seed_key  = data;
            CFG_RUN_LEN:   run_len   = data[7:0];
            CFG_WIDE_TAPS: wide_taps = data[0];
            default: ;
        endcase
    endfunction

    function void predict_word(logic restart);
        logic [31:0] mix;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic        last;
        if (restart) begin
            blk_key = seed_key;
            start_block();
            restart_cnt++;
        end
        mix = 32'd0;
        if (wide_taps) begin
            for (int k = 0; k < 8; k++) begin
                mix ^= table_word(tap_pos + 8'(k)) << k;
            end
            wide_cnt++;
        end else begin
            mix = (table_word(tap_pos + 8'd6) << 6) ^ (table_word(tap_pos + 8'd7) << 7);
        end
        d = {24'd0, low_byte};
        a = (d ^ mix) ^ (blk_key + acc_a);
        b = (blk_key + a) ^ (mix + d);
        c = rot_left((a >> XS_MID) ^ a, b);
        acc_a    = a;
        low_byte = c[7:0];
        last     = (words_left <= 8'd1);
        pending_words.push_back(t_word_res'{c, last});
        if (last) begin
            blk_key += WEYL_STEP;
            start_block();
            block_cnt++;
        end else begin
            words_left--;
            tap_pos--;
        end
    endfunction

    task flag_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task check_word(logic [31:0] word, logic blk_end);
        t_word_res want;
        if (pending_words.size() == 0) begin
            flag_mismatch($sformatf("word %08h with no request outstanding", word));
            return;
        end
        want = pending_words.pop_front();
        if (word !== want.word) begin
            flag_mismatch($sformatf("word #%0d: got %08h, want %08h",
                                    word_cnt, word, want.word));
        end
        if (blk_end !== want.block_end) begin
            flag_mismatch($sformatf("word #%0d: block_end got %b, want %b",
                                    word_cnt, blk_end, want.block_end));
        end
        word_cnt++;
    endtask
endclass

module keyed_table_prng_stream_test;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_restart   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [31:0]          o_word;
    logic                 o_block_end;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;

    keyed_word_tracker tracker = new();
    bit                restart_plan[$];
    bit                send_done;

    keyed_table_prng_stream u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_word      (o_word),
        .o_block_end (o_block_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_word(o_word, o_block_end);
        end
    end

    initial begin
        #10_000_000;
        $display("timeout: words still outstanding or handshake hung");
        $display("TEST FAILED");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.apply_register(idx, data);
    endtask

    task automatic send_requests(int idle_pct);
        int total;
        int sent;
        total = restart_plan.size();
        sent  = 0;
        while (sent < total) begin
            @(posedge i_clk);
            if (i_in_valid && !o_in_stall) begin
                tracker.predict_word(i_restart);
                sent++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (sent < total && $urandom_range(99) >= idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_restart  <= restart_plan[sent];
                end else begin
                    i_in_valid <= 1'b0;
                    i_restart  <= 1'($urandom_range(1));
                end
            end
        end
        send_done = 1'b1;
    endtask

    // hold-off counted here, independent of the request side
    task automatic drive_stall(int stall_pct, int hold);
        int held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (send_done && tracker.pending_words.size() == 0) begin
                i_out_stall <= 1'b0;
                break;
            end
            if (held < hold) begin
                i_out_stall <= 1'b1;
                held++;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    endtask

    task automatic run_items(int idle_pct, int stall_pct, int hold);
        send_done = 1'b0;
        fork
            send_requests(idle_pct);
            drive_stall(stall_pct, hold);
        join
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        restart_plan.delete();
    endtask

    task automatic run_phase(logic [31:0] base, logic [7:0] len, logic wide, int restart_pct,
                             int count, int idle_pct, int stall_pct, int hold);
        write_reg(CFG_SEED_KEY, base);
        write_reg(CFG_RUN_LEN, {24'($urandom), len});
        write_reg(CFG_WIDE_TAPS, {31'($urandom), wide});
        for (int n = 0; n < count; n++) begin
            if (n == 0) begin
                restart_plan.push_back(1'($urandom_range(1)));
            end else begin
                restart_plan.push_back($urandom_range(99) < restart_pct);
            end
        end
        run_items(idle_pct, stall_pct, hold);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, then restart mid-block
        restart_plan = '{0, 0, 0, 0, 1};
        run_items(0, 0, 0);

        // one-word blocks, eight taps, key wraps on rekey
        write_reg(CFG_RUN_LEN, 32'd1);
        write_reg(CFG_WIDE_TAPS, 32'd1);
        write_reg(CFG_SEED_KEY, 32'hffff_ffff);
        restart_plan = '{1, 0, 0};
        run_items(0, 0, 0);

        // zero length acts as one
        write_reg(CFG_RUN_LEN, 32'd0);
        restart_plan = '{1, 0, 0};
        run_items(0, 0, 0);

        // unused index ignored, upper data bits ignored
        write_reg(CFG_SPARE, $urandom());
        write_reg(CFG_RUN_LEN, 32'hffff_ff03);
        write_reg(CFG_WIDE_TAPS, 32'hffff_fffe);
        write_reg(CFG_SEED_KEY, 32'h0);
        restart_plan = '{1, 0, 0, 0, 0, 0};
        run_items(0, 0, 0);

        run_phase($urandom(), 8'd255, 1'b0, 0, 270, 0, 0, HOLD_CYCLES);
        run_phase(32'hffff_ffff, 8'($urandom_range(1, 8)), 1'b1, 4, 120, 71, 0, 0);
        run_phase($urandom(), 8'($urandom_range(1, 8)), 1'b0, 4, 120, 0, 71, 0);
        run_phase($urandom(), 8'($urandom_range(1, 6)), 1'b1, 8, 100, 25, 25, 0);
        run_phase($urandom(), 8'd255, 1'b1, 1, 150, 25, 25, 0);
        run_phase(32'h0, 8'd1, 1'b0, 15, 80, 71, 0, 0);

        if (tracker.pending_words.size() != 0) begin
            tracker.flag_mismatch($sformatf("%0d words never arrived",
                                            tracker.pending_words.size()));
        end
        $display("checked %0d words over %0d finished blocks, %0d restarts, %0d eight-tap",
                 tracker.word_cnt, tracker.block_cnt, tracker.restart_cnt, tracker.wide_cnt);
        $display("key/length extremes, zero length, full 255-word block, idling, hold-off");
        if (tracker.err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
